/* rtl/lbc_pkg.sv */
package lbc_pkg;

  localparam int CNT_W      = 11;  // counters never exceed twice a 10-bit half period
  localparam int HALF_W     = 10;
  localparam int LED_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STR_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STR_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STR_C  = 3'd4;

  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_FAST   = 3'd2;
  localparam logic [2:0] MODE_SLOW   = 3'd3;
  localparam logic [2:0] MODE_STROBE = 3'd4;

  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic             func;
    logic [LED_W-1:0] led_index;
    logic [2:0]       mode;
  } in_item_t;

  typedef struct packed {
    logic             serial_bit;
    logic [LED_W-1:0] bit_index;
    logic             last_bit;
  } out_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] fast_half;
    logic [HALF_W-1:0] slow_half;
    logic [LED_W-1:0]  str_a;
    logic [LED_W-1:0]  str_b;
    logic [LED_W-1:0]  str_c;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_SET,
    OP_BLINK,
    OP_STROBE,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [LED_W-1:0]  led;
    logic              lit_val;
    logic [HALF_W-1:0] half;
  } q_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] on_count;
    logic [CNT_W-1:0] off_count;
    logic [CNT_W-1:0] on_reload;
    logic [CNT_W-1:0] off_reload;
  } rec_t;

  typedef enum logic [1:0] {
    ROLE_FIRST,
    ROLE_SECOND,
    ROLE_THIRD
  } role_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMD_RD,
    B_CMD_WR,
    B_TICK,
    B_TICK_END,
    B_FRAME
  } back_state_t;

endpackage

/* rtl/led_blink_controller.sv */
// LED blink controller: per-LED on/off/fast/slow blink plus a three-LED
// strobe, with the LED frame shifted out one bit per LED.
//
// Input channel: an item is taken on a clock edge with start high and busy
// low. func selects a mode command for led_index, or a tick. Commands and
// ticks enter a two-entry queue; busy is high while it is full.
// Result channel: out_strobe marks each bit of a frame for one cycle,
// highest LED first, last_bit set on LED 0. There is no back-pressure, the
// receiver must take every bit as it comes.
// Configuration: cfg_valid/cfg_ready write port, always ready; registers
// are half periods and strobe LED indexes. Write them only when idle.
//
// Execution: the executor handles one item at a time. A command reads and
// writes the record of its LED (a strobe reads and writes per strobe LED).
// A tick walks the record store, one LED read per cycle with write-back in
// the cycle after each read, then, if a command was taken or an LED toggled
// since the last frame, shifts out the frame. The first frame bit follows
// the walk, the tick-end state and the output register.
// Reset: all LEDs off with zero counters and reloads, registers at their
// defaults, and a frame pending so the first tick sends a frame.
module led_blink_controller #(
  parameter int LED_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  lbc_pkg::in_item_t                   in_item,
  // frame output
  output logic                                out_strobe,
  output lbc_pkg::out_item_t                  out_item,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lbc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  lbc_pkg::cfg_t     cfg_r;
  logic              q_full;
  logic              q_not_empty;
  logic              q_push;
  logic              q_pop;
  lbc_pkg::q_entry_t q_in;
  lbc_pkg::q_entry_t q_head;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  // register bank; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_half <= lbc_pkg::HALF_W'(6);
      cfg_r.slow_half <= lbc_pkg::HALF_W'(15);
      cfg_r.str_a     <= lbc_pkg::LED_W'(0);
      cfg_r.str_b     <= lbc_pkg::LED_W'(1);
      cfg_r.str_c     <= lbc_pkg::LED_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lbc_pkg::CFG_FAST:  cfg_r.fast_half <= cfg_data[lbc_pkg::HALF_W-1:0];
        lbc_pkg::CFG_SLOW:  cfg_r.slow_half <= cfg_data[lbc_pkg::HALF_W-1:0];
        lbc_pkg::CFG_STR_A: cfg_r.str_a     <= cfg_data[lbc_pkg::LED_W-1:0];
        lbc_pkg::CFG_STR_B: cfg_r.str_b     <= cfg_data[lbc_pkg::LED_W-1:0];
        lbc_pkg::CFG_STR_C: cfg_r.str_c     <= cfg_data[lbc_pkg::LED_W-1:0];
        default: ;
      endcase
    end
  end

  // front: decode and filter items
  lbc_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .in_item (in_item),
    .take    (start && !busy),
    .cfg     (cfg_r),
    .push    (q_push),
    .entry   (q_in)
  );

  // queue between decode and execution
  lbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back: record updates, tick walk and frame shift
  lbc_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_not_empty),
    .q_entry    (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

/* rtl/lbc_front.sv */
module lbc_front #(
  parameter int LED_COUNT = 16
) (
  input  lbc_pkg::in_item_t in_item,
  input  logic              take,
  input  lbc_pkg::cfg_t     cfg,
  output logic              push,
  output lbc_pkg::q_entry_t entry
);

  logic in_range;

  assign in_range = {1'b0, in_item.led_index} < 7'(LED_COUNT);

  // Decode the item; bad modes and out-of-range LEDs never reach the queue.
  always_comb begin
    push          = 1'b0;
    entry.op      = lbc_pkg::OP_TICK;
    entry.led     = in_item.led_index;
    entry.lit_val = in_item.mode[0];
    entry.half    = cfg.fast_half;
    priority if (in_item.func == lbc_pkg::FUNC_TICK) begin
      push = take;
    end else begin
      priority case (in_item.mode)
        lbc_pkg::MODE_OFF, lbc_pkg::MODE_ON: begin
          push     = take && in_range;
          entry.op = lbc_pkg::OP_SET;
        end
        lbc_pkg::MODE_FAST: begin
          push     = take && in_range;
          entry.op = lbc_pkg::OP_BLINK;
        end
        lbc_pkg::MODE_SLOW: begin
          push       = take && in_range;
          entry.op   = lbc_pkg::OP_BLINK;
          entry.half = cfg.slow_half;
        end
        lbc_pkg::MODE_STROBE: begin
          push     = take;
          entry.op = lbc_pkg::OP_STROBE;
        end
        default: push = 1'b0;
      endcase
    end
  end

endmodule

/* rtl/lbc_fifo.sv */
module lbc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lbc_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output lbc_pkg::q_entry_t head
);

  localparam logic [lbc_pkg::Q_PTR_W:0] DEPTH = (lbc_pkg::Q_PTR_W + 1)'(lbc_pkg::Q_DEPTH);

  lbc_pkg::q_entry_t             slot_r [lbc_pkg::Q_DEPTH];
  logic [lbc_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [lbc_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [lbc_pkg::Q_PTR_W:0]     count_r;

  assign full      = count_r == DEPTH;
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |=> count_r == DEPTH)
    else $error("queue count moved while full");
`endif

endmodule

/* rtl/lbc_back.sv */
module lbc_back #(
  parameter int LED_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lbc_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  lbc_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_strobe,
  output lbc_pkg::out_item_t out_item
);

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam int LED_W_EXT = lbc_pkg::LED_W + 1;

  lbc_pkg::back_state_t state_r, state_nxt;
  lbc_pkg::q_entry_t    cur_r, cur_nxt;
  lbc_pkg::role_t       role_r, role_nxt;
  logic [IDX_W-1:0]     ridx_r, ridx_nxt;
  logic [IDX_W-1:0]     fidx_r, fidx_nxt;
  logic                 wb_tick_r;
  logic [IDX_W-1:0]     wb_idx_r;
  logic [LED_COUNT-1:0] lit_r;
  logic                 frame_pending_r;
  logic                 out_vld_r, out_vld_nxt;
  lbc_pkg::out_item_t   out_item_r, out_item_nxt;

  // per-LED record store, valid bits give the all-zero reset
  lbc_pkg::rec_t        mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_r;
  lbc_pkg::rec_t        rd_data_r;
  logic                 rd_vld_r;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  lbc_pkg::rec_t        wr_data;
  logic                 lit_we;
  logic                 lit_val;
  logic                 fp_set;
  logic                 fp_clr;

  lbc_pkg::rec_t        rec_in;
  logic [LED_W_EXT-1:0] tgt_led;
  logic                 tgt_ok;
  logic                 last_role;
  logic [lbc_pkg::CNT_W-1:0] half_c;
  logic [lbc_pkg::CNT_W-1:0] full_c;
  logic [lbc_pkg::CNT_W-1:0] cnt_dec;
  logic                 cur_lit;

  assign rec_in = rd_vld_r ? rd_data_r : '0;
  assign half_c = lbc_pkg::CNT_W'(cfg.fast_half);
  assign full_c = {half_c[lbc_pkg::CNT_W-2:0], 1'b0};
  assign cur_lit = lit_r[wb_idx_r];

  // LED the current command step works on
  always_comb begin
    tgt_led   = {1'b0, cur_r.led};
    last_role = 1'b1;
    if (cur_r.op == lbc_pkg::OP_STROBE) begin
      unique case (role_r)
        lbc_pkg::ROLE_FIRST: begin
          tgt_led   = {1'b0, cfg.str_a};
          last_role = 1'b0;
        end
        lbc_pkg::ROLE_SECOND: begin
          tgt_led   = {1'b0, cfg.str_b};
          last_role = 1'b0;
        end
        lbc_pkg::ROLE_THIRD: tgt_led = {1'b0, cfg.str_c};
        default: tgt_led = {1'b0, cfg.str_c};
      endcase
    end
    tgt_ok = tgt_led < LED_W_EXT'(LED_COUNT);
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    role_nxt     = role_r;
    ridx_nxt     = ridx_r;
    fidx_nxt     = fidx_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = ridx_r;
    wr_en        = 1'b0;
    wr_addr      = wb_idx_r;
    wr_data      = rec_in;
    lit_we       = 1'b0;
    lit_val      = cur_lit;
    fp_set       = 1'b0;
    fp_clr       = 1'b0;
    out_vld_nxt  = 1'b0;
    out_item_nxt = out_item_r;
    cnt_dec      = '0;

    // tick write-back, in the cycle after the read
    if (wb_tick_r) begin
      wr_en  = 1'b1;
      lit_we = 1'b1;
      if (cur_lit) begin
        if (rec_in.on_count != '0) begin
          cnt_dec          = rec_in.on_count - 1'b1;
          wr_data.on_count = cnt_dec;
          if (cnt_dec == '0) begin
            wr_data.off_count = rec_in.off_reload;
            lit_val           = 1'b0;
            fp_set            = 1'b1;
          end
        end
      end else begin
        if (rec_in.off_count != '0) begin
          cnt_dec           = rec_in.off_count - 1'b1;
          wr_data.off_count = cnt_dec;
          if (cnt_dec == '0) begin
            wr_data.on_count = rec_in.on_reload;
            lit_val          = 1'b1;
            fp_set           = 1'b1;
          end
        end
      end
    end

    unique case (state_r)
      lbc_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cur_nxt  = q_entry;
          role_nxt = lbc_pkg::ROLE_FIRST;
          ridx_nxt = '0;
          if (q_entry.op == lbc_pkg::OP_TICK) begin
            state_nxt = lbc_pkg::B_TICK;
          end else begin
            fp_set    = 1'b1;
            state_nxt = lbc_pkg::B_CMD_RD;
          end
        end
      end
      lbc_pkg::B_CMD_RD: begin
        rd_addr = IDX_W'(tgt_led);
        if (tgt_ok) begin
          rd_en     = 1'b1;
          state_nxt = lbc_pkg::B_CMD_WR;
        end else if (last_role) begin
          state_nxt = lbc_pkg::B_IDLE;
        end else begin
          role_nxt = lbc_pkg::role_t'(role_r + 1'b1);
        end
      end
      lbc_pkg::B_CMD_WR: begin
        wr_en   = 1'b1;
        lit_we  = 1'b1;
        wr_addr = IDX_W'(tgt_led);
        unique case (cur_r.op)
          lbc_pkg::OP_SET: begin
            wr_data.on_count  = '0;
            wr_data.off_count = '0;
            lit_val           = cur_r.lit_val;
          end
          lbc_pkg::OP_BLINK: begin
            wr_data.on_count   = lbc_pkg::CNT_W'(cur_r.half);
            wr_data.off_count  = lbc_pkg::CNT_W'(cur_r.half);
            wr_data.on_reload  = lbc_pkg::CNT_W'(cur_r.half);
            wr_data.off_reload = lbc_pkg::CNT_W'(cur_r.half);
            lit_val            = 1'b1;
          end
          lbc_pkg::OP_STROBE: begin
            wr_data.on_reload  = half_c;
            wr_data.off_reload = full_c;
            unique case (role_r)
              lbc_pkg::ROLE_FIRST: begin
                wr_data.on_count = half_c;
                lit_val          = 1'b1;
              end
              lbc_pkg::ROLE_SECOND: begin
                wr_data.off_count = half_c;
                lit_val           = 1'b0;
              end
              lbc_pkg::ROLE_THIRD: begin
                wr_data.off_count = full_c;
                lit_val           = 1'b0;
              end
              default: lit_val = 1'b0;
            endcase
          end
          default: wr_en = 1'b0;
        endcase
        if (last_role) begin
          state_nxt = lbc_pkg::B_IDLE;
        end else begin
          role_nxt  = lbc_pkg::role_t'(role_r + 1'b1);
          state_nxt = lbc_pkg::B_CMD_RD;
        end
      end
      lbc_pkg::B_TICK: begin
        rd_en    = 1'b1;
        rd_addr  = ridx_r;
        ridx_nxt = ridx_r + 1'b1;
        if (ridx_r == LAST_IDX) begin
          state_nxt = lbc_pkg::B_TICK_END;
        end
      end
      lbc_pkg::B_TICK_END: begin
        fidx_nxt = LAST_IDX;
        if (frame_pending_r || fp_set) begin
          fp_clr    = 1'b1;
          state_nxt = lbc_pkg::B_FRAME;
        end else begin
          state_nxt = lbc_pkg::B_IDLE;
        end
      end
      lbc_pkg::B_FRAME: begin
        out_vld_nxt             = 1'b1;
        out_item_nxt.serial_bit = ~lit_r[fidx_r];
        out_item_nxt.bit_index  = lbc_pkg::LED_W'(fidx_r);
        out_item_nxt.last_bit   = fidx_r == '0;
        fidx_nxt                = fidx_r - 1'b1;
        if (fidx_r == '0) begin
          state_nxt = lbc_pkg::B_IDLE;
        end
      end
      default: state_nxt = lbc_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= lbc_pkg::B_IDLE;
      role_r          <= lbc_pkg::ROLE_FIRST;
      ridx_r          <= '0;
      fidx_r          <= '0;
      wb_tick_r       <= 1'b0;
      lit_r           <= '0;
      valid_r         <= '0;
      frame_pending_r <= 1'b1;
      out_vld_r       <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      role_r          <= role_nxt;
      ridx_r          <= ridx_nxt;
      fidx_r          <= fidx_nxt;
      wb_tick_r       <= state_r == lbc_pkg::B_TICK;
      frame_pending_r <= fp_clr ? 1'b0 : (frame_pending_r | fp_set);
      out_vld_r       <= out_vld_nxt;
      if (lit_we) begin
        lit_r[wr_addr] <= lit_val;
      end
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    wb_idx_r   <= ridx_r;
    out_item_r <= out_item_nxt;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= valid_r[rd_addr];
    end
  end

  assign out_strobe = out_vld_r;
  assign out_item   = out_item_r;

`ifndef SYNTHESIS
  a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.last_bit |-> out_item_r.bit_index == '0)
    else $error("last bit not on LED zero");

  a_frame_descends: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_item_r.last_bit |=>
      out_vld_r && out_item_r.bit_index == $past(out_item_r.bit_index) - 1'b1)
    else $error("frame bits out of order");

  a_frame_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.last_bit |=> !out_vld_r)
    else $error("strobe continues past frame end");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != lbc_pkg::B_IDLE && !out_vld_r)
    else $error("popped item not taken up");
`endif

endmodule
